[hdl/hbc_pkg.sv]
package hbc_pkg;

	localparam int unsigned FRAME_WIDTH  = 1024;
	localparam int unsigned FRAME_HEIGHT = 1024;
	localparam int unsigned MAX_MATCHES  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int unsigned CNT_W        = $clog2(MAX_MATCHES) + 1;

	localparam int unsigned HUE_HALF     = 1440;
	localparam int unsigned HUE_FULL     = 2880;
	localparam int unsigned HUE_BIAS     = HUE_HALF + 3 * HUE_FULL;
	localparam logic [18:0] FIXED_RADIUS = 19'd2560;

	localparam int unsigned DVD_W     = 42;
	localparam int unsigned DIV_STEPS = DVD_W;
	localparam int unsigned VAR_W     = 22;
	localparam int unsigned RAD_W     = VAR_W + 16;
	localparam int unsigned ROOT_W    = RAD_W / 2;

	localparam logic [2:0] CFG_HUE_TARGET    = 3'd0;
	localparam logic [2:0] CFG_HUE_TOLERANCE = 3'd1;
	localparam logic [2:0] CFG_SAT_TARGET    = 3'd2;
	localparam logic [2:0] CFG_SAT_TOLERANCE = 3'd3;
	localparam logic [2:0] CFG_VAL_TARGET    = 3'd4;
	localparam logic [2:0] CFG_VAL_TOLERANCE = 3'd5;
	localparam logic [2:0] CFG_RADIUS_ENABLE = 3'd6;

	typedef enum logic [1:0] {
		DIV_X,
		DIV_Y,
		DIV_V
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIVX_GO,
		S_DIVX_WAIT,
		S_DIVY_GO,
		S_DIVY_WAIT,
		S_MUL_A,
		S_MUL_B,
		S_MUL_C,
		S_ACC,
		S_DIVV_GO,
		S_DIVV_WAIT,
		S_SQRT_GO,
		S_SQRT_WAIT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic     acc;
		logic     clear;
		logic     out_load;
		logic     out_frame;
		logic     out_held;
		logic     blob_empty;
		logic     blob_write;
		logic     div_start;
		div_sel_t div_sel;
		logic     mul_a;
		logic     mul_b;
		logic     mul_c;
		logic     spr_acc;
		logic     axis;
		logic     sqrt_start;
	} cmd_t;

	typedef struct packed {
		logic empty_next;
		logic div_done;
		logic sqrt_done;
		logic radius_en;
	} sts_t;

	function automatic logic [13:0] hue_wrap(input logic [13:0] v);
		logic [13:0] r;
		r = v;
		for (int i = 0; i < 5; i++) begin
			if (r >= 14'(HUE_FULL)) begin
				r = r - 14'(HUE_FULL);
			end
		end
		return r;
	endfunction

endpackage

[hdl/hbc_divider.sv]
module hbc_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hbc_pkg::DVD_W-1:0]   dividend,
	input  logic [hbc_pkg::CNT_W-1:0]   divisor,
	output logic [hbc_pkg::DVD_W-1:0]   quotient,
	output logic                        done
);

	logic [hbc_pkg::DVD_W-1:0] dvd_q;
	logic [hbc_pkg::CNT_W-1:0] rem_q;
	logic [5:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [hbc_pkg::CNT_W:0]   rem_sh;
	logic                      ge;

	assign rem_sh = {rem_q, dvd_q[hbc_pkg::DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(hbc_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? hbc_pkg::CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[hbc_pkg::CNT_W-1:0];
			dvd_q <= {dvd_q[hbc_pkg::DVD_W-2:0], ge};
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

[hdl/hbc_sqrt.sv]
module hbc_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [hbc_pkg::RAD_W-1:0]    radicand,
	output logic [hbc_pkg::ROOT_W-1:0]   root,
	output logic                         done
);

	logic [hbc_pkg::RAD_W-1:0]  rad_q;
	logic [hbc_pkg::ROOT_W+1:0] rem_q;
	logic [hbc_pkg::ROOT_W-1:0] root_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [hbc_pkg::ROOT_W+3:0] rem_sh;
	logic [hbc_pkg::ROOT_W+3:0] trial;
	logic                       ge;

	assign rem_sh = {rem_q, rad_q[hbc_pkg::RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(hbc_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[hbc_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= ge ? (hbc_pkg::ROOT_W+2)'(rem_sh - trial)
			             : rem_sh[hbc_pkg::ROOT_W+1:0];
			root_q <= {root_q[hbc_pkg::ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

[hdl/hbc_ctrl.sv]
module hbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          frame_last,
	input  logic          out_ready,
	input  hbc_pkg::sts_t sts,
	output logic          in_ready,
	output logic          out_valid,
	output hbc_pkg::cmd_t cmd
);

	hbc_pkg::state_t state_q, state_d;
	logic            axis_q;
	logic            out_valid_q;
	logic            slot_free;
	logic            accept;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == hbc_pkg::S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hbc_pkg::S_IDLE: begin
				if (accept && frame_last && !sts.empty_next) begin
					state_d = hbc_pkg::S_DIVX_GO;
				end
			end
			hbc_pkg::S_DIVX_GO:   state_d = hbc_pkg::S_DIVX_WAIT;
			hbc_pkg::S_DIVX_WAIT: if (sts.div_done) state_d = hbc_pkg::S_DIVY_GO;
			hbc_pkg::S_DIVY_GO:   state_d = hbc_pkg::S_DIVY_WAIT;
			hbc_pkg::S_DIVY_WAIT: begin
				if (sts.div_done) begin
					state_d = sts.radius_en ? hbc_pkg::S_MUL_A : hbc_pkg::S_FIN;
				end
			end
			hbc_pkg::S_MUL_A:     state_d = hbc_pkg::S_MUL_B;
			hbc_pkg::S_MUL_B:     state_d = hbc_pkg::S_MUL_C;
			hbc_pkg::S_MUL_C:     state_d = hbc_pkg::S_ACC;
			hbc_pkg::S_ACC:       state_d = axis_q ? hbc_pkg::S_DIVV_GO : hbc_pkg::S_MUL_A;
			hbc_pkg::S_DIVV_GO:   state_d = hbc_pkg::S_DIVV_WAIT;
			hbc_pkg::S_DIVV_WAIT: if (sts.div_done) state_d = hbc_pkg::S_SQRT_GO;
			hbc_pkg::S_SQRT_GO:   state_d = hbc_pkg::S_SQRT_WAIT;
			hbc_pkg::S_SQRT_WAIT: if (sts.sqrt_done) state_d = hbc_pkg::S_FIN;
			hbc_pkg::S_FIN:       if (slot_free) state_d = hbc_pkg::S_IDLE;
			default:              state_d = hbc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.div_sel = hbc_pkg::DIV_X;
		cmd.axis    = axis_q;
		case (state_q)
			hbc_pkg::S_IDLE: begin
				cmd.acc = accept;
				if (accept && (!frame_last || sts.empty_next)) begin
					cmd.out_load   = 1'b1;
					cmd.out_frame  = frame_last;
					cmd.blob_empty = frame_last;
					cmd.clear      = frame_last;
				end
			end
			hbc_pkg::S_DIVX_GO:   cmd.div_start = 1'b1;
			hbc_pkg::S_DIVX_WAIT: cmd.div_sel = hbc_pkg::DIV_X;
			hbc_pkg::S_DIVY_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = hbc_pkg::DIV_Y;
			end
			hbc_pkg::S_DIVY_WAIT: cmd.div_sel = hbc_pkg::DIV_Y;
			hbc_pkg::S_MUL_A:     cmd.mul_a = 1'b1;
			hbc_pkg::S_MUL_B:     cmd.mul_b = 1'b1;
			hbc_pkg::S_MUL_C:     cmd.mul_c = 1'b1;
			hbc_pkg::S_ACC:       cmd.spr_acc = 1'b1;
			hbc_pkg::S_DIVV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = hbc_pkg::DIV_V;
			end
			hbc_pkg::S_DIVV_WAIT: cmd.div_sel = hbc_pkg::DIV_V;
			hbc_pkg::S_SQRT_GO:   cmd.sqrt_start = 1'b1;
			hbc_pkg::S_SQRT_WAIT: cmd.div_sel = hbc_pkg::DIV_V;
			hbc_pkg::S_FIN: begin
				if (slot_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_frame  = 1'b1;
					cmd.out_held   = 1'b1;
					cmd.blob_write = 1'b1;
					cmd.clear      = 1'b1;
				end
			end
			default: cmd.div_sel = hbc_pkg::DIV_X;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hbc_pkg::S_IDLE;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hbc_pkg::S_DIVX_GO) begin
				axis_q <= 1'b0;
			end else if (state_q == hbc_pkg::S_ACC) begin
				axis_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/hbc_datapath.sv]
module hbc_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  hbc_pkg::cmd_t cmd,
	output hbc_pkg::sts_t sts,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [12:0]   cfg_data,
	input  logic [7:0]    pix_hue,
	input  logic [7:0]    pix_sat,
	input  logic [7:0]    pix_val,
	input  logic [9:0]    pix_x,
	input  logic [9:0]    pix_y,
	output logic          is_match,
	output logic          frame_done,
	output logic          blob_visible,
	output logic [9:0]    centre_x,
	output logic [9:0]    centre_y,
	output logic [18:0]   radius
);

	logic [12:0] hue_target_q, sat_target_q, val_target_q;
	logic [11:0] hue_tol_q, sat_tol_q, val_tol_q;
	logic        radius_en_q;

	logic [29:0]               sum_x_q, sum_y_q;
	logic [39:0]               sum_xx_q, sum_yy_q;
	logic [hbc_pkg::CNT_W-1:0] count_q;

	logic        seen_q;
	logic [9:0]  col_q, row_q;
	logic [18:0] size_q;
	logic        is_match_q, frame_done_q, match_last_q;

	logic [9:0]  cx_q, cy_q;
	logic [39:0] m1_q;
	logic [19:0] m2_q;
	logic [40:0] m3_q;
	logic [41:0] tot_q;

	logic              hue_on, sat_on, val_on;
	logic [13:0]       hue_r;
	logic signed [14:0] hue_d, sat_d, val_d, tol_h;
	logic              hue_ok, sat_ok, val_ok, match, acc_en;

	logic [9:0]          ax_c;
	logic [29:0]         ax_s;
	logic [39:0]         ax_sq;
	logic signed [42:0]  spread;

	logic [hbc_pkg::DVD_W-1:0]  div_dvd, div_q;
	logic                       div_done;
	logic [hbc_pkg::ROOT_W-1:0] root;
	logic                       sqrt_done;

	assign hue_on = !hue_target_q[12];
	assign sat_on = !sat_target_q[12];
	assign val_on = !val_target_q[12];

	assign hue_r = hbc_pkg::hue_wrap(14'($signed({hue_target_q[12], hue_target_q})
	                                 - $signed({2'b00, pix_hue, 4'b0000})
	                                 + 15'(hbc_pkg::HUE_BIAS)));
	assign hue_d = $signed({1'b0, hue_r}) - 15'(hbc_pkg::HUE_HALF);
	assign tol_h = $signed({3'b000, hue_tol_q});
	assign hue_ok = (hue_d >= -tol_h) && (hue_d <= tol_h);

	always_comb begin
		sat_d = $signed({3'b000, pix_sat, 4'b0000}) - $signed({{2{sat_target_q[12]}}, sat_target_q});
		val_d = $signed({3'b000, pix_val, 4'b0000}) - $signed({{2{val_target_q[12]}}, val_target_q});
		if (sat_d < 0) begin
			sat_d = -sat_d;
		end
		if (val_d < 0) begin
			val_d = -val_d;
		end
	end
	assign sat_ok = sat_d < $signed({3'b000, sat_tol_q});
	assign val_ok = val_d < $signed({3'b000, val_tol_q});

	assign match  = (hue_on || sat_on || val_on) && (!hue_on || hue_ok)
	                && (!sat_on || sat_ok) && (!val_on || val_ok);
	assign acc_en = cmd.acc && match && !count_q[hbc_pkg::CNT_W-1];

	assign sts.empty_next = (count_q == '0) && !acc_en;
	assign sts.div_done   = div_done;
	assign sts.sqrt_done  = sqrt_done;
	assign sts.radius_en  = radius_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_target_q <= 13'd120;
			hue_tol_q    <= 12'd40;
			sat_target_q <= 13'h1FF0;
			sat_tol_q    <= 12'd102;
			val_target_q <= 13'h1FF0;
			val_tol_q    <= 12'd102;
			radius_en_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				hbc_pkg::CFG_HUE_TARGET:    hue_target_q <= cfg_data;
				hbc_pkg::CFG_HUE_TOLERANCE: hue_tol_q    <= cfg_data[11:0];
				hbc_pkg::CFG_SAT_TARGET:    sat_target_q <= cfg_data;
				hbc_pkg::CFG_SAT_TOLERANCE: sat_tol_q    <= cfg_data[11:0];
				hbc_pkg::CFG_VAL_TARGET:    val_target_q <= cfg_data;
				hbc_pkg::CFG_VAL_TOLERANCE: val_tol_q    <= cfg_data[11:0];
				hbc_pkg::CFG_RADIUS_ENABLE: radius_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			count_q  <= '0;
			tot_q    <= '0;
			seen_q   <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			size_q   <= '0;
		end else begin
			if (cmd.clear) begin
				sum_x_q  <= '0;
				sum_y_q  <= '0;
				sum_xx_q <= '0;
				sum_yy_q <= '0;
				count_q  <= '0;
				tot_q    <= '0;
			end else begin
				if (acc_en) begin
					sum_x_q  <= sum_x_q + 30'(pix_x);
					sum_y_q  <= sum_y_q + 30'(pix_y);
					sum_xx_q <= sum_xx_q + 40'({10'd0, pix_x} * {10'd0, pix_x});
					sum_yy_q <= sum_yy_q + 40'({10'd0, pix_y} * {10'd0, pix_y});
					count_q  <= count_q + 1'b1;
				end
				if (cmd.spr_acc) begin
					tot_q <= tot_q + (spread < 0 ? 42'd0 : spread[41:0]);
				end
			end
			if (cmd.blob_empty) begin
				seen_q <= 1'b0;
			end else if (cmd.blob_write) begin
				seen_q <= 1'b1;
				col_q  <= cx_q;
				row_q  <= cy_q;
				size_q <= radius_en_q ? 19'(root) : hbc_pkg::FIXED_RADIUS;
			end
		end
	end

	assign ax_c  = cmd.axis ? cy_q : cx_q;
	assign ax_s  = cmd.axis ? sum_y_q : sum_x_q;
	assign ax_sq = cmd.axis ? sum_yy_q : sum_xx_q;
	assign spread = $signed({3'b000, ax_sq}) - $signed({2'b00, m1_q, 1'b0})
	                + $signed({2'b00, m3_q});

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			match_last_q <= match;
		end
		if (cmd.out_load) begin
			is_match_q   <= cmd.out_held ? match_last_q : match;
			frame_done_q <= cmd.out_frame;
		end
		if (div_done && cmd.div_sel == hbc_pkg::DIV_X) begin
			cx_q <= div_q[9:0];
		end
		if (div_done && cmd.div_sel == hbc_pkg::DIV_Y) begin
			cy_q <= div_q[9:0];
		end
		if (cmd.mul_a) begin
			m1_q <= ax_c * ax_s;
		end
		if (cmd.mul_b) begin
			m2_q <= ax_c * ax_c;
		end
		if (cmd.mul_c) begin
			m3_q <= count_q * m2_q;
		end
	end

	always_comb begin
		case (cmd.div_sel)
			hbc_pkg::DIV_X: div_dvd = hbc_pkg::DVD_W'(sum_x_q);
			hbc_pkg::DIV_Y: div_dvd = hbc_pkg::DVD_W'(sum_y_q);
			hbc_pkg::DIV_V: div_dvd = tot_q;
			default:        div_dvd = '0;
		endcase
	end

	hbc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (count_q),
		.quotient (div_q),
		.done     (div_done)
	);

	hbc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand ({div_q[hbc_pkg::VAR_W-1:0], 16'h0000}),
		.root     (root),
		.done     (sqrt_done)
	);

	assign is_match     = is_match_q;
	assign frame_done   = frame_done_q;
	assign blob_visible = seen_q;
	assign centre_x     = col_q;
	assign centre_y     = row_q;
	assign radius       = size_q;

endmodule

[hdl/hsv_blob_centroid_tracker.sv]
// HSV colour blob tracker. Every accepted pixel yields one result transaction with its
// match flag and the current blob fields. Ordinary pixels are taken one per cycle; a
// one-entry output register holds each result, and the next pixel is taken in the cycle
// that result leaves. The pixel flagged frame_last closes the frame; the bit-serial
// divider (centroid x, centroid y and variance, 42 steps each) and the 19-step square
// root run in turn, and with radius disabled only the centroid x and y divisions run. An
// empty frame closes without them. No pixel is accepted until the frame has closed.
module hsv_blob_centroid_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pix_hue,
	input  logic [7:0]  pix_sat,
	input  logic [7:0]  pix_val,
	input  logic [9:0]  pix_x,
	input  logic [9:0]  pix_y,
	input  logic        frame_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_match,
	output logic        frame_done,
	output logic        blob_visible,
	output logic [9:0]  centre_x,
	output logic [9:0]  centre_y,
	output logic [18:0] radius
);

	hbc_pkg::cmd_t cmd;
	hbc_pkg::sts_t sts;

	hbc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.frame_last (frame_last),
		.out_ready  (out_ready),
		.sts        (sts),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.cmd        (cmd)
	);

	hbc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pix_hue      (pix_hue),
		.pix_sat      (pix_sat),
		.pix_val      (pix_val),
		.pix_x        (pix_x),
		.pix_y        (pix_y),
		.is_match     (is_match),
		.frame_done   (frame_done),
		.blob_visible (blob_visible),
		.centre_x     (centre_x),
		.centre_y     (centre_y),
		.radius       (radius)
	);

endmodule
